[rtl/core/ufrb_pkg.sv]
// ----------------------------------------------------------------------------
// ufrb_pkg
// Shared types and constants for the uart fifo register block.
// ----------------------------------------------------------------------------
`default_nettype none

package ufrb_pkg;

  // fifo geometry
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

  // register port geometry
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int THR_W      = 8;
  // threshold compare width, wide enough for an 8-bit threshold and any level
  localparam int CMP_W      = (LVL_W > THR_W + 1) ? LVL_W : THR_W + 1;

  localparam int ACT_W      = 3;
  localparam int BYTE_W     = 8;

  // access codes
  typedef enum logic [ACT_W-1:0] {
    ACT_READ    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_INJECT  = 3'd2,
    ACT_CONSUME = 3'd3,
    ACT_PEEK    = 3'd4
  } action_e;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UART_EN   = 2'd0,
    CFG_LOOPBACK  = 2'd1,
    CFG_RX_IRQ_EN = 2'd2,
    CFG_IRQ_THR   = 2'd3
  } cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/ufrb_if.sv]
// ----------------------------------------------------------------------------
// ufrb_if
// Valid/ready channels for access transactions and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufrb_in_if;
  import ufrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] byte_in;

  modport source (output valid, output action, output byte_in, input ready);
  modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface ufrb_out_if;
  import ufrb_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              ok;
  logic [LVL_W-1:0]  tx_level;
  logic [LVL_W-1:0]  rx_level;
  logic              tx_space;
  logic              rx_ready;
  logic              rx_full;
  logic              tx_full;
  logic              rx_irq;

  modport source (
    output valid, output byte_out, output ok, output tx_level, output rx_level,
    output tx_space, output rx_ready, output rx_full, output tx_full,
    output rx_irq, input ready
  );
  modport sink (
    input valid, input byte_out, input ok, input tx_level, input rx_level,
    input tx_space, input rx_ready, input rx_full, input tx_full,
    input rx_irq, output ready
  );
endinterface

`default_nettype wire

[rtl/core/uart_fifo_register_block.sv]
// Results: an accepted transaction runs once the result register is free and
//   its result is registered; the controller accepts, then executes, a
//   transaction before taking the next; one transaction is taken while a result waits.
// Reset: rst_ni is asynchronous, active low; both fifos come up empty,
//   loopback and rx interrupt off, threshold 1. Fifo contents are not cleared.
// ----------------------------------------------------------------------------
// uart_fifo_register_block
// UART register front end with transmit and receive byte fifos.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_fifo_register_block (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ufrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ufrb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ufrb_in_if.sink                              in_if,
  ufrb_out_if.source                           out_if
);
  import ufrb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // access sequencer
  ufrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // fifos, config and result register
  ufrb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (in_if.action),
    .byte_in_i   (in_if.byte_in),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .byte_out_o  (out_if.byte_out),
    .ok_o        (out_if.ok),
    .tx_level_o  (out_if.tx_level),
    .rx_level_o  (out_if.rx_level),
    .tx_space_o  (out_if.tx_space),
    .rx_ready_o  (out_if.rx_ready),
    .rx_full_o   (out_if.rx_full),
    .tx_full_o   (out_if.tx_full),
    .rx_irq_o    (out_if.rx_irq)
  );

endmodule

`default_nettype wire

[rtl/core/ufrb_ctrl.sv]
// ----------------------------------------------------------------------------
// ufrb_ctrl
// Access sequencer: takes one transaction, then runs it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output ufrb_pkg::cmd_t        cmd_o,
  input  wire ufrb_pkg::status_t status_i
);
  import ufrb_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  // accept only while no access is pending
  assign in_ready_o     = (state_q == S_IDLE);
  assign cmd_o.capture  = in_valid_i && in_ready_o;
  assign cmd_o.execute  = (state_q == S_EXEC) && status_i.out_free;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/ufrb_datapath.sv]
// ----------------------------------------------------------------------------
// ufrb_datapath
// Config registers, transmit and receive byte fifos and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufrb_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // register port
  input  wire logic                            cfg_we_i,
  input  wire logic [ufrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ufrb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // access payload
  input  wire logic [ufrb_pkg::ACT_W-1:0]      action_i,
  input  wire logic [ufrb_pkg::BYTE_W-1:0]     byte_in_i,
  // control
  input  wire ufrb_pkg::cmd_t                  cmd_i,
  output ufrb_pkg::status_t                    status_o,
  // result
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [ufrb_pkg::BYTE_W-1:0]          byte_out_o,
  output logic                                 ok_o,
  output logic [ufrb_pkg::LVL_W-1:0]           tx_level_o,
  output logic [ufrb_pkg::LVL_W-1:0]           rx_level_o,
  output logic                                 tx_space_o,
  output logic                                 rx_ready_o,
  output logic                                 rx_full_o,
  output logic                                 tx_full_o,
  output logic                                 rx_irq_o
);
  import ufrb_pkg::*;

  localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // config registers (the uart enable bit has no effect and is not kept)
  logic             loopback_q;
  logic             rx_irq_en_q;
  logic [THR_W-1:0] irq_thr_q;

  // captured access
  logic [ACT_W-1:0]  act_q;
  logic [BYTE_W-1:0] byte_q;

  // fifo storage and pointers
  logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
  logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
  logic [LVL_W-1:0]  tx_cnt_q, rx_cnt_q, tx_cnt_d, rx_cnt_d;

  // result register
  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_out_q;
  logic              ok_q;
  logic [LVL_W-1:0]  tx_level_q, rx_level_q;
  logic              tx_space_q, rx_ready_q, rx_full_q, tx_full_q, rx_irq_q;

  // access decode
  logic tx_push, rx_push, tx_pop, rx_pop, peek;
  logic tx_push_ok, rx_push_ok, tx_pop_ok, rx_pop_ok;
  logic tx_is_full, rx_is_full;
  logic [CMP_W-1:0] thr_eff;
  logic             irq_d;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loopback_q  <= 1'b0;
      rx_irq_en_q <= 1'b0;
      irq_thr_q   <= THR_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOOPBACK:  loopback_q  <= cfg_wdata_i[0];
        CFG_RX_IRQ_EN: rx_irq_en_q <= cfg_wdata_i[0];
        CFG_IRQ_THR:   irq_thr_q   <= cfg_wdata_i[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  // capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_i;
      byte_q <= byte_in_i;
    end
  end

  // decode and fifo outcome
  always_comb begin
    tx_push = 1'b0;
    rx_push = 1'b0;
    tx_pop  = 1'b0;
    rx_pop  = 1'b0;
    peek    = 1'b0;
    case (act_q)
      ACT_READ:    rx_pop  = 1'b1;
      ACT_WRITE: begin
        rx_push = loopback_q;
        tx_push = !loopback_q;
      end
      ACT_INJECT:  rx_push = 1'b1;
      ACT_CONSUME: tx_pop  = 1'b1;
      ACT_PEEK:    peek    = 1'b1;
      default:     ;
    endcase

    tx_is_full = (tx_cnt_q == LVL_FULL);
    rx_is_full = (rx_cnt_q == LVL_FULL);
    tx_push_ok = tx_push && !tx_is_full;
    rx_push_ok = rx_push && !rx_is_full;
    tx_pop_ok  = tx_pop && (tx_cnt_q != '0);
    rx_pop_ok  = rx_pop && (rx_cnt_q != '0);

    tx_cnt_d = tx_cnt_q;
    rx_cnt_d = rx_cnt_q;
    if (tx_push_ok) tx_cnt_d = tx_cnt_q + LVL_W'(1);
    if (tx_pop_ok)  tx_cnt_d = tx_cnt_q - LVL_W'(1);
    if (rx_push_ok) rx_cnt_d = rx_cnt_q + LVL_W'(1);
    if (rx_pop_ok)  rx_cnt_d = rx_cnt_q - LVL_W'(1);

    // out-of-range threshold behaves as one
    if (irq_thr_q == '0 || CMP_W'(irq_thr_q) > CMP_W'(FIFO_DEPTH)) begin
      thr_eff = CMP_W'(1);
    end else begin
      thr_eff = CMP_W'(irq_thr_q);
    end
    irq_d = rx_irq_en_q && (CMP_W'(rx_cnt_d) >= thr_eff);
  end

  // fifo pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      tx_cnt_q  <= '0;
      rx_cnt_q  <= '0;
    end else if (cmd_i.execute) begin
      if (tx_push_ok) tx_tail_q <= (tx_tail_q == PTR_LAST) ? '0 : tx_tail_q + PTR_W'(1);
      if (rx_push_ok) rx_tail_q <= (rx_tail_q == PTR_LAST) ? '0 : rx_tail_q + PTR_W'(1);
      if (tx_pop_ok)  tx_head_q <= (tx_head_q == PTR_LAST) ? '0 : tx_head_q + PTR_W'(1);
      if (rx_pop_ok)  rx_head_q <= (rx_head_q == PTR_LAST) ? '0 : rx_head_q + PTR_W'(1);
      tx_cnt_q <= tx_cnt_d;
      rx_cnt_q <= rx_cnt_d;
    end
  end

  // fifo storage writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && tx_push_ok) tx_mem[tx_tail_q] <= byte_q;
    if (cmd_i.execute && rx_push_ok) rx_mem[rx_tail_q] <= byte_q;
  end

  // result payload, popped byte read straight into the register
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      if (rx_pop_ok) begin
        byte_out_q <= rx_mem[rx_head_q];
      end else if (tx_pop_ok) begin
        byte_out_q <= tx_mem[tx_head_q];
      end else begin
        byte_out_q <= '0;
      end
      ok_q       <= tx_push_ok || rx_push_ok || tx_pop_ok || rx_pop_ok || peek;
      tx_level_q <= tx_cnt_d;
      rx_level_q <= rx_cnt_d;
      tx_space_q <= (tx_cnt_d != LVL_FULL);
      rx_ready_q <= (rx_cnt_d != '0);
      rx_full_q  <= (rx_cnt_d == LVL_FULL);
      tx_full_q  <= (tx_cnt_d == LVL_FULL);
      rx_irq_q   <= irq_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign byte_out_o  = byte_out_q;
  assign ok_o        = ok_q;
  assign tx_level_o  = tx_level_q;
  assign rx_level_o  = rx_level_q;
  assign tx_space_o  = tx_space_q;
  assign rx_ready_o  = rx_ready_q;
  assign rx_full_o   = rx_full_q;
  assign tx_full_o   = tx_full_q;
  assign rx_irq_o    = rx_irq_q;

  // fill counts never pass the depth
  a_tx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt_q <= LVL_FULL)
    else $error("tx fill count above depth");

  a_rx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_cnt_q <= LVL_FULL)
    else $error("rx fill count above depth");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  // a nonzero byte only comes from a successful pop
  a_byte_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && byte_out_q != '0) |-> ok_q)
    else $error("byte returned without a successful pop");

  // result level reflects the count after the transaction
  a_level_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.execute |=> (rx_level_q == rx_cnt_q && tx_level_q == tx_cnt_q))
    else $error("result levels do not match fifo counts");

endmodule

`default_nettype wire

[tb/ufrb_access_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufrb_access_checker
// Watches the access, result and register channels of the uart fifo register
// block, predicts every result from its own copy of the fifos and registers,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------

module ufrb_access_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ufrb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ufrb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ufrb_in_if                              in_if,
  ufrb_out_if                             out_if,
  output int                              fail_count_o,
  output int                              pending_o
);
  import ufrb_pkg::*;

  localparam int MAX_REPORTS = 10;
  localparam int TX_Q        = 0;
  localparam int RX_Q        = 1;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              ok;
    logic [LVL_W-1:0]  tx_level;
    logic [LVL_W-1:0]  rx_level;
    logic              tx_space;
    logic              rx_ready;
    logic              rx_full;
    logic              tx_full;
    logic              rx_irq;
  } access_result_t;

  // predicted fifo state, index TX_Q or RX_Q
  logic [BYTE_W-1:0] fifo_mem [2][FIFO_DEPTH];
  logic [PTR_W-1:0]  fifo_rd  [2];
  logic [PTR_W-1:0]  fifo_wr  [2];
  logic [LVL_W-1:0]  fifo_cnt [2];

  // predicted register contents
  logic              uart_en_q;
  logic              loopback_q;
  logic              rx_irq_en_q;
  logic [THR_W-1:0]  irq_thr_q;

  access_result_t    expected_results [$];
  int                mismatches = 0;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic fifo_push(int q, logic [BYTE_W-1:0] b);
    if (fifo_cnt[q] == LVL_W'(FIFO_DEPTH)) return 1'b0;
    fifo_mem[q][fifo_wr[q]] = b;
    fifo_wr[q] = ptr_next(fifo_wr[q]);
    fifo_cnt[q] = fifo_cnt[q] + 1'b1;
    return 1'b1;
  endfunction

  // a failed pop hands back zero
  function automatic logic fifo_pop(int q, output logic [BYTE_W-1:0] b);
    b = '0;
    if (fifo_cnt[q] == '0) return 1'b0;
    b = fifo_mem[q][fifo_rd[q]];
    fifo_rd[q] = ptr_next(fifo_rd[q]);
    fifo_cnt[q] = fifo_cnt[q] - 1'b1;
    return 1'b1;
  endfunction

  // performs one access on the predicted state and returns the status it gives
  function automatic access_result_t apply_access(logic [ACT_W-1:0] act,
                                                  logic [BYTE_W-1:0] data);
    access_result_t    r;
    logic [BYTE_W-1:0] popped;
    logic [CMP_W-1:0]  thr;
    r      = '0;
    popped = '0;
    case (act)
      ACT_READ:    r.ok = fifo_pop(RX_Q, popped);
      ACT_WRITE:   r.ok = fifo_push(loopback_q ? RX_Q : TX_Q, data);
      ACT_INJECT:  r.ok = fifo_push(RX_Q, data);
      ACT_CONSUME: r.ok = fifo_pop(TX_Q, popped);
      ACT_PEEK:    r.ok = 1'b1;
      default:     r.ok = 1'b0;
    endcase
    // out of range thresholds behave as one
    thr = CMP_W'(irq_thr_q);
    if (thr == '0 || thr > CMP_W'(FIFO_DEPTH)) thr = CMP_W'(1);
    r.byte_out = popped;
    r.tx_level = fifo_cnt[TX_Q];
    r.rx_level = fifo_cnt[RX_Q];
    r.tx_space = fifo_cnt[TX_Q] < LVL_W'(FIFO_DEPTH);
    r.rx_ready = fifo_cnt[RX_Q] != '0;
    r.rx_full  = fifo_cnt[RX_Q] == LVL_W'(FIFO_DEPTH);
    r.tx_full  = fifo_cnt[TX_Q] == LVL_W'(FIFO_DEPTH);
    r.rx_irq   = rx_irq_en_q && (CMP_W'(fifo_cnt[RX_Q]) >= thr);
    return r;
  endfunction

  function automatic string describe(access_result_t r);
    return $sformatf({"byte=%02h ok=%0d tx_lvl=%0d rx_lvl=%0d tx_space=%0d ",
                      "rx_ready=%0d rx_full=%0d tx_full=%0d rx_irq=%0d"},
                     r.byte_out, r.ok, r.tx_level, r.rx_level, r.tx_space,
                     r.rx_ready, r.rx_full, r.tx_full, r.rx_irq);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t got;
    access_result_t want;
    if (!rst_ni) begin
      for (int q = 0; q < 2; q++) begin
        fifo_rd[q]  = '0;
        fifo_wr[q]  = '0;
        fifo_cnt[q] = '0;
      end
      uart_en_q   = 1'b1;
      loopback_q  = 1'b0;
      rx_irq_en_q = 1'b0;
      irq_thr_q   = THR_W'(1);
      expected_results.delete();
      pending_o <= 0;
    end else begin
      // result transaction leaving the block
      if (out_if.valid && out_if.ready) begin
        got.byte_out = out_if.byte_out;
        got.ok       = out_if.ok;
        got.tx_level = out_if.tx_level;
        got.rx_level = out_if.rx_level;
        got.tx_space = out_if.tx_space;
        got.rx_ready = out_if.rx_ready;
        got.rx_full  = out_if.rx_full;
        got.tx_full  = out_if.tx_full;
        got.rx_irq   = out_if.rx_irq;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with none expected: %s", $time, describe(got));
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                       $time, describe(want), describe(got));
          end
        end
      end

      // access transaction entering the block, queued behind older ones
      if (in_if.valid && in_if.ready)
        expected_results.insert(expected_results.size(),
                                apply_access(in_if.action, in_if.byte_in));

      // register writes, only made while the block is idle
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UART_EN:   uart_en_q   = cfg_wdata_i[0];
          CFG_LOOPBACK:  loopback_q  = cfg_wdata_i[0];
          CFG_RX_IRQ_EN: rx_irq_en_q = cfg_wdata_i[0];
          CFG_IRQ_THR:   irq_thr_q   = cfg_wdata_i[THR_W-1:0];
          default: ;
        endcase
      end

      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/uart_fifo_register_block_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_fifo_register_block_tb
// Drives register writes and access transactions into the uart fifo register
// block under random source gaps and sink stalls, with one long sink hold-off
// that backs the block up, and reports the verdict from the checker.
// ----------------------------------------------------------------------------

module uart_fifo_register_block_tb;
  import ufrb_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 90;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  // longest correct stretch without a transaction is the sink hold-off plus the
  // result latency and a source gap, so this leaves a wide margin
  localparam int STALL_LIMIT   = 5 * HOLD_CYCLES;

  typedef enum int {
    TRAFFIC_MIX,
    TRAFFIC_FILL,
    TRAFFIC_DRAIN
  } traffic_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  logic                  calm = 1'b0;
  logic                  hold_req = 1'b0;
  logic                  hold_done = 1'b0;
  int                    fail_count;
  int                    pending;
  int                    stall_cycles = 0;

  ufrb_in_if  in_ch ();
  ufrb_out_if out_ch ();

  uart_fifo_register_block u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  ufrb_access_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_if        (in_ch),
    .out_if       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog on transaction progress
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("uart_fifo_register_block_tb failed");
      $finish;
    end
  end

  // result sink: random stall bursts, one long hold-off, steady when calm
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // register data with random upper bits for the one-bit registers
  function automatic logic [CFG_DATA_W-1:0] flag_word(logic b);
    logic [CFG_DATA_W-1:0] w;
    w    = CFG_DATA_W'($urandom);
    w[0] = b;
    return w;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(traffic_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      TRAFFIC_FILL: begin
        if (roll < 45) return ACT_WRITE;
        if (roll < 90) return ACT_INJECT;
        if (roll < 95) return ACT_PEEK;
        return (roll < 98) ? ACT_READ : ACT_CONSUME;
      end
      TRAFFIC_DRAIN: begin
        if (roll < 45) return ACT_READ;
        if (roll < 90) return ACT_CONSUME;
        if (roll < 95) return ACT_PEEK;
        return (roll < 98) ? ACT_WRITE : ACT_INJECT;
      end
      default: begin
        if (roll < 20) return ACT_READ;
        if (roll < 40) return ACT_WRITE;
        if (roll < 60) return ACT_INJECT;
        if (roll < 80) return ACT_CONSUME;
        if (roll < 92) return ACT_PEEK;
        // unused access codes
        return ACT_W'($urandom_range(int'(ACT_PEEK) + 1, (1 << ACT_W) - 1));
      end
    endcase
  endfunction

  // one access transaction, with an occasional source gap ahead of it
  task automatic send_access(input logic [ACT_W-1:0] act, input logic [BYTE_W-1:0] data);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.byte_in <= data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic uart_en, input logic loop_en,
                            input logic irq_en, input logic [THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_UART_EN;
    cfg_wdata <= flag_word(uart_en);
    @(posedge clk);
    cfg_idx   <= CFG_LOOPBACK;
    cfg_wdata <= flag_word(loop_en);
    @(posedge clk);
    cfg_idx   <= CFG_RX_IRQ_EN;
    cfg_wdata <= flag_word(irq_en);
    @(posedge clk);
    cfg_idx   <= CFG_IRQ_THR;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // bursts of fill, drain or mixed accesses with random bytes
  task automatic run_traffic(input int n_items);
    int       sent;
    int       burst;
    traffic_e mode;
    sent = 0;
    while (sent < n_items) begin
      mode  = traffic_e'($urandom_range(0, 2));
      burst = $urandom_range(4, 40);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        send_access(pick_action(mode), BYTE_W'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_PEEK;
    in_ch.byte_in <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_UART_EN;
    cfg_wdata     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: status at reset, empty pops, byte extremes, unused codes
    send_access(ACT_PEEK, 8'h00);
    send_access(ACT_READ, 8'hFF);
    send_access(ACT_CONSUME, 8'hFF);
    send_access(ACT_WRITE, 8'h00);
    send_access(ACT_WRITE, 8'hFF);
    send_access(ACT_WRITE, 8'hA5);
    send_access(ACT_WRITE, 8'h5A);
    repeat (5) send_access(ACT_CONSUME, 8'h00);
    send_access(ACT_INJECT, 8'hFF);
    send_access(ACT_INJECT, 8'h00);
    send_access(ACT_PEEK, 8'hFF);
    repeat (3) send_access(ACT_READ, 8'h00);
    for (int c = int'(ACT_PEEK) + 1; c < (1 << ACT_W); c++)
      send_access(ACT_W'(c), 8'hC3);

    // random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: set_config(1'b1, 1'b0, 1'b1, THR_W'(1));
        1: set_config(1'b0, 1'b1, 1'b1, THR_W'(FIFO_DEPTH));
        2: set_config(1'b1, 1'b1, 1'b1, '0);
        3: set_config(1'b0, 1'b0, 1'b1, '1);
        4: set_config(1'b1, 1'b0, 1'b0, THR_W'(FIFO_DEPTH + 1));
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                            THR_W'($urandom_range(0, 255)));
      endcase
      if (ph == 1) hold_req <= 1'b1;
      if (ph == NUM_PHASES - 1) calm <= 1'b1;
      run_traffic(PHASE_ITEMS);
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("uart_fifo_register_block_tb passed");
    end else begin
      $display("uart_fifo_register_block_tb failed");
    end
    $finish;
  end

endmodule
